[sv/crr_pkg.sv]
// Shared types and constants for the Catmull-Rom ribbon interpolator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package crr_pkg;

  // Sample geometry: six coordinates per sample, four samples in the window.
  localparam int COORDS = 6;
  localparam int WIN = 4;
  localparam int FILL_W = 3;

  // Field widths on the result channel.
  localparam int STEP_W = 4;

  // Width of the exact curve numerator (largest magnitude stays below 2^48).
  localparam int NW = 50;

  // Register stages from lane input to lane result.
  localparam int LANE_LAT = 10;

  // Defaults for the top-level parameters.
  localparam int STEPS_DEF = 10;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Curve coefficients of one coordinate, taken from window samples P0..P3.
  typedef struct packed {
    logic signed [31:0] p1;  // P1
    logic signed [32:0] a;   // P2 - P0
    logic signed [35:0] b;   // 2P0 - 5P1 + 4P2 - P3
    logic signed [35:0] c;   // -P0 + 3P1 - 3P2 + P3
  } coef_t;

  // Coefficients of all six coordinates of one segment.
  typedef coef_t [COORDS-1:0] coef_set_t;

endpackage

`default_nettype wire

[sv/crr_ifs.sv]
// Valid/ready channel interfaces for samples in and interpolated pairs out.
// Depends on crr_pkg for the step index width.
`default_nettype none

interface crr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] begin_x;
  logic signed [31:0] begin_y;
  logic signed [31:0] begin_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic               restart;

  modport source (
    output valid, begin_x, begin_y, begin_z, end_x, end_y, end_z, restart,
    input  ready
  );
  modport sink (
    input  valid, begin_x, begin_y, begin_z, end_x, end_y, end_z, restart,
    output ready
  );
endinterface

interface crr_out_if import crr_pkg::*;;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_begin_x;
  logic signed [31:0] out_begin_y;
  logic signed [31:0] out_begin_z;
  logic signed [31:0] out_end_x;
  logic signed [31:0] out_end_y;
  logic signed [31:0] out_end_z;
  logic [STEP_W-1:0]  step_index;
  logic               last_of_run;

  modport source (
    output valid, out_begin_x, out_begin_y, out_begin_z,
           out_end_x, out_end_y, out_end_z, step_index, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, out_begin_x, out_begin_y, out_begin_z,
           out_end_x, out_end_y, out_end_z, step_index, last_of_run,
    output ready
  );
endinterface

`default_nettype wire

[sv/crr_front.sv]
// Front end: takes sample transfers, keeps the four-sample window and the
// fill count, and pushes one coefficient set per full window. Uses crr_pkg.
`default_nettype none

module crr_front import crr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  crr_in_if.sink     samples,
  output coef_set_t  wdata,
  output logic       push,
  input  wire logic  full
);

  logic [31:0]       win [WIN][COORDS];
  logic [31:0]       in_c [COORDS];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              emit;
  logic              accept;

  // A pending coefficient set blocks new samples until the queue takes it.
  assign samples.ready = !emit || !full;
  assign accept        = samples.valid && samples.ready;
  assign push          = emit && !full;

  assign in_c[0] = samples.begin_x;
  assign in_c[1] = samples.begin_y;
  assign in_c[2] = samples.begin_z;
  assign in_c[3] = samples.end_x;
  assign in_c[4] = samples.end_y;
  assign in_c[5] = samples.end_z;

  // Restart makes this sample the first one held; the count saturates.
  always_comb begin
    if (samples.restart) begin
      fill_next = FILL_W'(1);
    end else if (fill == FILL_W'(WIN)) begin
      fill_next = fill;
    end else begin
      fill_next = FILL_W'(fill + 1'b1);
    end
  end

  // Fill count and the pending flag for a full window.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      emit <= 1'b0;
    end else if (accept) begin
      fill <= fill_next;
      emit <= (fill_next == FILL_W'(WIN));
    end else if (push) begin
      emit <= 1'b0;
    end
  end

  // Window shift. Entries older than a restart are never read, because the
  // fill count keeps them out of any coefficient set.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WIN - 1; i++) begin
        win[i] <= win[i+1];
      end
      for (int j = 0; j < COORDS; j++) begin
        win[WIN-1][j] <= in_c[j];
      end
    end
  end

  // Coefficients of every coordinate from the held window.
  always_comb begin
    logic signed [35:0] p0, p1, p2, p3, d;
    for (int j = 0; j < COORDS; j++) begin
      p0 = 36'($signed(win[0][j]));
      p1 = 36'($signed(win[1][j]));
      p2 = 36'($signed(win[2][j]));
      p3 = 36'($signed(win[3][j]));
      d  = p1 - p2;
      wdata[j].p1 = $signed(win[1][j]);
      wdata[j].a  = 33'(p2 - p0);
      wdata[j].b  = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
      wdata[j].c  = p3 - p0 + (d <<< 1) + d;
    end
  end

endmodule

`default_nettype wire

[sv/crr_queue.sv]
// Small first-in first-out queue of coefficient sets between the front end
// and the back end. Uses crr_pkg for the entry type.
`default_nettype none

module crr_queue import crr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire coef_set_t  wdata,
  output logic            full,
  input  wire logic       pop,
  output coef_set_t       rdata,
  output logic            valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  coef_set_t     mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

[sv/crr_lane.sv]
// One coordinate lane: evaluates the curve numerator at step k, rounds by
// exact division by 2*STEPS^3 through a reciprocal, and saturates. Uses crr_pkg.
`default_nettype none

module crr_lane import crr_pkg::*; #(
  parameter int STEPS = STEPS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire coef_t                      coef,
  input  wire logic [$clog2(STEPS)-1:0]   k,
  output logic [31:0]                     res
);

  localparam int KW  = $clog2(STEPS);
  localparam int S3  = STEPS * STEPS * STEPS;
  localparam int DIV = 2 * S3;
  localparam int DW  = $clog2(DIV + 1);
  localparam int MW  = 32 + DW;
  localparam longint RECIP_L = (longint'(1) << (31 + DW)) / longint'(DIV);
  localparam longint OFF_L   = longint'(DIV) * (longint'(1) << 31);
  localparam logic [32:0]          RECIP = 33'(RECIP_L);
  localparam logic signed [NW-1:0] OFF   = NW'(OFF_L);
  localparam logic signed [NW-1:0] HALF  = NW'(S3);
  localparam logic signed [NW-1:0] DIV_N = NW'(DIV);
  localparam logic [MW-1:0]        DIV_M = MW'(DIV);
  localparam logic [DW+1:0]        DIV_R = (DW+2)'(DIV);

  // Step weights k*S^2, k^2*S and k^3 as small constant tables.
  function automatic logic signed [NW-1:0] w_lin(input logic [KW-1:0] kk);
    return NW'(int'(kk) * STEPS * STEPS);
  endfunction

  function automatic logic signed [NW-1:0] w_sq(input logic [KW-1:0] kk);
    return NW'(int'(kk) * int'(kk) * STEPS);
  endfunction

  function automatic logic signed [NW-1:0] w_cube(input logic [KW-1:0] kk);
    return NW'(int'(kk) * int'(kk) * int'(kk));
  endfunction

  logic signed [NW-1:0] p1_e, a_e, b_e, c_e;
  logic signed [NW-1:0] t0, t1, t2, t3;
  logic signed [NW-1:0] s01, s23, m;
  logic [1:0]           sat_pipe [7];
  logic [MW-1:0]        mp_d, mp_e, mp_f;
  logic [32:0]          mh;
  logic [65:0]          prod_e;
  logic [31:0]          q0_e, q0_f, q_g;
  logic [MW-1:0]        qd_f;
  logic [DW+1:0]        r_g;
  logic [DW+1:0]        r_h [3];
  logic [31:0]          q_h [3];
  logic [DW+1:0]        r_src [3];
  logic [31:0]          q_src [3];

  assign p1_e   = NW'(coef.p1);
  assign a_e    = NW'(coef.a);
  assign b_e    = NW'(coef.b);
  assign c_e    = NW'(coef.c);
  assign mh     = mp_d[MW-1:DW-1];
  assign prod_e = 66'(mh) * 66'(RECIP);

  // Correction stages take the remainder from the stage before.
  always_comb begin
    r_src[0] = r_g;
    q_src[0] = q_g;
    for (int i = 1; i < 3; i++) begin
      r_src[i] = r_h[i-1];
      q_src[i] = q_h[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Products of the four curve terms.
      t0 <= p1_e * DIV_N;
      t1 <= a_e * w_lin(k);
      t2 <= b_e * w_sq(k);
      t3 <= c_e * w_cube(k);
      // Numerator plus half the divisor, summed in two steps.
      s01 <= t0 + t1 + HALF;
      s23 <= t2 + t3;
      m   <= s01 + s23;
      // Saturation flags; the offset makes the in-range numerator positive.
      sat_pipe[0] <= {m >= OFF, m < -OFF};
      for (int i = 1; i < 7; i++) begin
        sat_pipe[i] <= sat_pipe[i-1];
      end
      mp_d <= MW'(m + OFF);
      // Quotient estimate from the reciprocal, at most three below the truth.
      q0_e <= prod_e[63:32];
      mp_e <= mp_d;
      qd_f <= MW'(q0_e) * DIV_M;
      q0_f <= q0_e;
      mp_f <= mp_e;
      r_g  <= (DW+2)'(mp_f - qd_f);
      q_g  <= q0_f;
      // Three compare-and-subtract steps settle the floor quotient.
      for (int i = 0; i < 3; i++) begin
        if (r_src[i] >= DIV_R) begin
          r_h[i] <= r_src[i] - DIV_R;
          q_h[i] <= q_src[i] + 32'd1;
        end else begin
          r_h[i] <= r_src[i];
          q_h[i] <= q_src[i];
        end
      end
    end
  end

  // Remove the offset by flipping the sign bit, or clamp.
  always_comb begin
    if (sat_pipe[6][1]) begin
      res = 32'h7FFF_FFFF;
    end else if (sat_pipe[6][0]) begin
      res = 32'h8000_0000;
    end else begin
      res = {~q_h[2][31], q_h[2][30:0]};
    end
  end

endmodule

`default_nettype wire

[sv/crr_back.sv]
// Back end: steps k through 0..STEPS-1 for the queue head, drives six
// coordinate lanes and the output register. Uses crr_pkg and crr_lane.
`default_nettype none

module crr_back import crr_pkg::*; #(
  parameter int STEPS = STEPS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire coef_set_t  head,
  input  wire logic       head_valid,
  output logic            pop,
  crr_out_if.source       pairs
);

  localparam int KW = $clog2(STEPS);

  logic          adv;
  logic          issue;
  logic          is_last;
  logic [KW-1:0] k;
  logic          mv [LANE_LAT];
  logic [KW-1:0] mk [LANE_LAT];
  logic          ml [LANE_LAT];
  logic [31:0]   res [COORDS];

  // The whole pipeline moves whenever the output register can take a value.
  assign adv     = !pairs.valid || pairs.ready;
  assign issue   = head_valid && adv;
  assign is_last = (k == KW'(STEPS - 1));
  assign pop     = issue && is_last;

  // Step counter over the current segment.
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (pop) begin
      k <= '0;
    end else if (issue) begin
      k <= KW'(k + 1'b1);
    end
  end

  // Step and last flag travel beside the lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        mv[i] <= 1'b0;
      end
    end else if (adv) begin
      mv[0] <= issue;
      for (int i = 1; i < LANE_LAT; i++) begin
        mv[i] <= mv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mk[0] <= k;
      ml[0] <= is_last;
      for (int i = 1; i < LANE_LAT; i++) begin
        mk[i] <= mk[i-1];
        ml[i] <= ml[i-1];
      end
    end
  end

  // One lane per coordinate.
  for (genvar j = 0; j < COORDS; j++) begin : g_lane
    crr_lane #(.STEPS(STEPS)) u_lane (
      .clk  (clk),
      .en   (adv),
      .coef (head[j]),
      .k    (k),
      .res  (res[j])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pairs.valid <= 1'b0;
    end else if (adv) begin
      pairs.valid <= mv[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pairs.out_begin_x <= res[0];
      pairs.out_begin_y <= res[1];
      pairs.out_begin_z <= res[2];
      pairs.out_end_x   <= res[3];
      pairs.out_end_y   <= res[4];
      pairs.out_end_z   <= res[5];
      pairs.step_index  <= STEP_W'(mk[LANE_LAT-1]);
      pairs.last_of_run <= ml[LANE_LAT-1];
    end
  end

endmodule

`default_nettype wire

[sv/catmull_rom_ribbon_interpolator_unit.sv]
// Top level of the Catmull-Rom ribbon interpolator: front end, queue, back end.
// Depends on crr_pkg, crr_ifs, crr_front, crr_queue and crr_back.
//
//   Channel   Direction  Payload                                   Transfer
//   samples   in         begin_x/y/z, end_x/y/z, restart           valid && ready
//   pairs     out        out_begin_x/y/z, out_end_x/y/z,           valid && ready
//                        step_index, last_of_run
//
// Each sample with a full window gives STEPS pairs, one per cycle while pairs does
// not stall; the back-end step counter sets this.
// The first pair of a segment passes the queue, the lane stages and the output register.
// Synchronous reset empties the window, the queue and the pipeline.
// A stall on pairs freezes the back end; the queue and the front end's pending set
// let samples keep coming until the queue holds QUEUE_DEPTH segments and a set waits.
`default_nettype none

module catmull_rom_ribbon_interpolator_unit import crr_pkg::*; #(
  parameter int STEPS       = STEPS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  crr_in_if.sink     samples,
  crr_out_if.source  pairs
);

  coef_set_t wdata;
  coef_set_t head;
  logic      push;
  logic      full;
  logic      pop;
  logic      head_valid;

  crr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .wdata   (wdata),
    .push    (push),
    .full    (full)
  );

  crr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .full  (full),
    .pop   (pop),
    .rdata (head),
    .valid (head_valid)
  );

  crr_back #(.STEPS(STEPS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .pairs      (pairs)
  );

endmodule

`default_nettype wire

[sv/crr_checker.sv]
// Port-level checks on the pair channel of the interpolator, bound to the
// top level. Uses crr_pkg for the step index width.
`default_nettype none

module crr_checker import crr_pkg::*; #(
  parameter int STEPS = STEPS_DEF
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              pairs_valid,
  input wire logic              pairs_ready,
  input wire logic [31:0]       out_begin_x,
  input wire logic [31:0]       out_begin_y,
  input wire logic [31:0]       out_begin_z,
  input wire logic [31:0]       out_end_x,
  input wire logic [31:0]       out_end_y,
  input wire logic [31:0]       out_end_z,
  input wire logic [STEP_W-1:0] step_index,
  input wire logic              last_of_run
);

  logic [STEP_W-1:0] exp_k;

  // Step expected on the next pair transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_k <= '0;
    end else if (pairs_valid && pairs_ready) begin
      exp_k <= last_of_run ? '0 : STEP_W'(step_index + 1'b1);
    end
  end

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !pairs_valid)
    else $error("pair valid after reset");

  // A stalled pair holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    pairs_valid && !pairs_ready |=> pairs_valid && $stable(step_index) &&
    $stable(last_of_run) && $stable(out_begin_x) && $stable(out_begin_y) &&
    $stable(out_begin_z) && $stable(out_end_x) && $stable(out_end_y) &&
    $stable(out_end_z))
    else $error("stalled pair changed");

  // The last flag marks exactly the final step.
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    pairs_valid |-> (last_of_run == (step_index == STEP_W'(STEPS - 1))))
    else $error("last flag does not match step index");

  // Steps count up from zero without gaps within each run.
  a_step_order: assert property (@(posedge clk) disable iff (rst)
    pairs_valid |-> (step_index == exp_k))
    else $error("step index out of order");

endmodule

bind catmull_rom_ribbon_interpolator_unit crr_checker #(.STEPS(STEPS)) u_crr_checker (
  .clk         (clk),
  .rst         (rst),
  .pairs_valid (pairs.valid),
  .pairs_ready (pairs.ready),
  .out_begin_x (pairs.out_begin_x),
  .out_begin_y (pairs.out_begin_y),
  .out_begin_z (pairs.out_begin_z),
  .out_end_x   (pairs.out_end_x),
  .out_end_y   (pairs.out_end_y),
  .out_end_z   (pairs.out_end_z),
  .step_index  (pairs.step_index),
  .last_of_run (pairs.last_of_run)
);

`default_nettype wire

[dv/crr_curve_checker.sv]
`timescale 1ns / 1ps
// Checker for the Catmull-Rom ribbon interpolator: watches both channels, predicts the pairs.
// Depends on crr_pkg and the channel interfaces in crr_ifs.

module crr_curve_checker import crr_pkg::*; #(
  parameter int STEPS = STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  crr_in_if    samples,
  crr_out_if   pairs,
  output int   fails,
  output int   pending
);

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int NFIELDS = COORDS + 2;

  // One expected pair: six coordinates, then step and last flag.
  typedef struct packed {
    logic [COORDS-1:0][31:0] coord;
    logic [STEP_W-1:0]       step;
    logic                    last;
  } pair_t;

  string field_name [NFIELDS] = '{"out_begin_x", "out_begin_y", "out_begin_z",
                                  "out_end_x", "out_end_y", "out_end_z",
                                  "step_index", "last_of_run"};

  // Sliding window of samples, oldest first, and how many are held.
  logic signed [31:0] win [WIN][COORDS];
  int                 fill;
  pair_t              expected_pairs [$];

  // One coordinate of the curve at t = k/STEPS, rounded to nearest
  // (ties upward) and clamped to the Q16.16 range.
  function automatic logic [31:0] curve_point(input longint p0, input longint p1,
                                              input longint p2, input longint p3,
                                              input longint k);
    longint s, s2, s3, a, b, c, num, den, q;
    s   = STEPS;
    s2  = s * s;
    s3  = s2 * s;
    a   = p2 - p0;
    b   = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c   = -p0 + 3 * p1 - 3 * p2 + p3;
    num = 2 * p1 * s3 + a * k * s2 + b * k * k * s + c * k * k * k + s3;
    den = 2 * s3;
    q   = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    if (q > Q_MAX) q = Q_MAX;
    if (q < Q_MIN) q = Q_MIN;
    return q[31:0];
  endfunction

  initial begin
    fails   = 0;
    pending = 0;
    fill    = 0;
  end

  always @(posedge clk) begin : watch
    pair_t                   want_pair;
    logic [31:0]             want [NFIELDS];
    logic [31:0]             got [NFIELDS];
    logic [COORDS-1:0][31:0] pt;
    bit                      bad;
    if (rst) begin
      expected_pairs.delete();
      for (int i = 0; i < WIN; i++)
        for (int j = 0; j < COORDS; j++) win[i][j] = '0;
      fill = 0;
    end else begin
      // Compare each pair transfer with the oldest expectation.
      if (pairs.valid && pairs.ready) begin
        got[0] = pairs.out_begin_x;
        got[1] = pairs.out_begin_y;
        got[2] = pairs.out_begin_z;
        got[3] = pairs.out_end_x;
        got[4] = pairs.out_end_y;
        got[5] = pairs.out_end_z;
        got[6] = 32'(pairs.step_index);
        got[7] = 32'(pairs.last_of_run);
        if (expected_pairs.size() == 0) begin
          if (fails < 10)
            $display("%0t: pair transfer with nothing expected (step %0d)",
                     $time, pairs.step_index);
          fails++;
        end else begin
          want_pair = expected_pairs[0];
          expected_pairs.delete(0);
          for (int j = 0; j < COORDS; j++) want[j] = want_pair.coord[j];
          want[6] = 32'(want_pair.step);
          want[7] = 32'(want_pair.last);
          bad = 1'b0;
          for (int f = 0; f < NFIELDS; f++) begin
            if (got[f] !== want[f]) begin
              bad = 1'b1;
              if (fails < 10)
                $display("%0t: %s expected %0d (0x%08h), got %0d (0x%08h)", $time,
                         field_name[f], $signed(want[f]), want[f], $signed(got[f]), got[f]);
            end
          end
          if (bad) fails++;
        end
      end

      // Each sample transfer shifts the window; a full window gives STEPS pairs.
      if (samples.valid && samples.ready) begin
        pt[0] = samples.begin_x;
        pt[1] = samples.begin_y;
        pt[2] = samples.begin_z;
        pt[3] = samples.end_x;
        pt[4] = samples.end_y;
        pt[5] = samples.end_z;
        if (samples.restart) begin
          for (int i = 0; i < WIN; i++)
            for (int j = 0; j < COORDS; j++) win[i][j] = '0;
          fill = 0;
        end
        for (int i = 0; i < WIN - 1; i++)
          for (int j = 0; j < COORDS; j++) win[i][j] = win[i+1][j];
        for (int j = 0; j < COORDS; j++) win[WIN-1][j] = pt[j];
        if (fill < WIN) fill++;
        if (fill == WIN) begin
          for (int k = 0; k < STEPS; k++) begin
            for (int j = 0; j < COORDS; j++)
              want_pair.coord[j] = curve_point(win[0][j], win[1][j], win[2][j],
                                               win[3][j], k);
            want_pair.step = STEP_W'(k);
            want_pair.last = (k == STEPS - 1);
            expected_pairs = {expected_pairs, want_pair};
          end
        end
      end
    end
    pending = expected_pairs.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Testbench top for catmull_rom_ribbon_interpolator_unit: clock, reset, samples and verdict.
// Depends on crr_pkg, crr_ifs, the block itself and crr_curve_checker.

module tb;
  import crr_pkg::*;

  localparam int LIMIT      = 200000;
  localparam int RAND_ITEMS = 380;
  localparam int HOLD_FROM  = 1500;
  localparam int HOLD_TO    = 1800;
  localparam int CALM_FROM  = 2600;
  localparam int CALM_TO    = 3800;
  localparam int DRAIN      = 40;

  localparam logic [31:0] PMAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] PMIN  = 32'h8000_0000;
  localparam logic [31:0] ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] ALT_A = 32'hAAAA_AAAA;
  localparam logic [31:0] ALT_5 = 32'h5555_5555;

  typedef enum {FULL_RANGE, NEAR_ZERO, EXTREME, DRIFT} value_style_t;

  // Coordinate order: begin x, y, z, end x, y, z.
  typedef struct packed {
    logic [COORDS-1:0][31:0] coord;
    logic                    restart;
  } sample_t;

  logic clk = 1'b0;
  logic rst;
  int   cycle = 0;
  int   rx_cycle = 0;
  int   fail_count;
  int   pending_pairs;

  crr_in_if  samples();
  crr_out_if pairs();

  catmull_rom_ribbon_interpolator_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .pairs   (pairs)
  );

  crr_curve_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .pairs   (pairs),
    .fails   (fail_count),
    .pending (pending_pairs)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
  end

  function automatic sample_t mk(input logic [31:0] bx, input logic [31:0] by,
                                 input logic [31:0] bz, input logic [31:0] ex,
                                 input logic [31:0] ey, input logic [31:0] ez,
                                 input logic restart);
    sample_t s;
    s.coord   = {ez, ey, ex, bz, by, bx};
    s.restart = restart;
    return s;
  endfunction

  function automatic value_style_t pick_style();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return FULL_RANGE;
    if (r < 65) return NEAR_ZERO;
    if (r < 75) return EXTREME;
    return DRIFT;
  endfunction

  function automatic logic [31:0] rand_coord(input logic [31:0] prev,
                                             input value_style_t style);
    case (style)
      FULL_RANGE: return $urandom;
      NEAR_ZERO:  return $urandom_range(0, 2097151) - 32'd1048576;
      EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return PMAX;
          1:       return PMIN;
          2:       return '0;
          3:       return ONES;
          default: return 32'd1;
        endcase
      end
      default:    return prev + $urandom_range(0, 8191) - 32'd4096;
    endcase
  endfunction

  // Offer one sample from a falling edge and hold it until the transfer.
  task automatic put_sample(input sample_t s);
    @(negedge clk);
    while (!(cycle >= CALM_FROM && cycle < CALM_TO) && $urandom_range(0, 99) < 7) begin
      samples.valid <= 1'b0;
      @(negedge clk);
    end
    samples.valid   <= 1'b1;
    samples.begin_x <= s.coord[0];
    samples.begin_y <= s.coord[1];
    samples.begin_z <= s.coord[2];
    samples.end_x   <= s.coord[3];
    samples.end_y   <= s.coord[4];
    samples.end_z   <= s.coord[5];
    samples.restart <= s.restart;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
  endtask

  // Pair receiver: random stalls, one long hold-off, and a stretch with none.
  initial begin
    pairs.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_TO)
        pairs.ready <= 1'b0;
      else if (rx_cycle >= CALM_FROM && rx_cycle < CALM_TO)
        pairs.ready <= 1'b1;
      else
        pairs.ready <= ($urandom_range(0, 99) >= 7);
    end
  end

  // Run limit in case the block hangs.
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("catmull_rom_ribbon_interpolator_unit test failed");
    $finish;
  end

  initial begin
    sample_t      directed_q [$];
    sample_t      s;
    sample_t      prev;
    value_style_t style;
    rst             = 1'b1;
    samples.valid   = 1'b0;
    samples.begin_x = '0;
    samples.begin_y = '0;
    samples.begin_z = '0;
    samples.end_x   = '0;
    samples.end_y   = '0;
    samples.end_z   = '0;
    samples.restart = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: fill from reset with alternating extremes, so the first
    // segments saturate both ways.
    directed_q = {directed_q, mk(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 1'b0)};
    directed_q = {directed_q, mk(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, 1'b0)};
    directed_q = {directed_q, mk(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 1'b0)};
    directed_q = {directed_q, mk(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, 1'b0)};
    // Mixed coordinates, bit patterns, zero and small signed values.
    directed_q = {directed_q, mk(PMAX, PMIN, '0, ONES, 32'd1, ALT_A, 1'b0)};
    directed_q = {directed_q, mk(PMIN, PMAX, ONES, '0, ALT_5, 32'd1, 1'b0)};
    directed_q = {directed_q, mk(ALT_5, ALT_A, 32'd1, PMIN, PMAX, '0, 1'b0)};
    directed_q = {directed_q, mk('0, '0, '0, '0, '0, '0, 1'b0)};
    directed_q = {directed_q, mk(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_8000,
                                 32'h0000_8000, 32'hFFFF_FFF9, 32'h0000_0007, 1'b0)};
    directed_q = {directed_q, mk(ONES, ONES, ONES, ONES, ONES, ONES, 1'b0)};
    // Restart on a full window, then again right away, then refill.
    directed_q = {directed_q, mk(32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 1'b1)};
    directed_q = {directed_q, mk(32'd7, 32'd8, 32'd9, 32'd10, 32'd11, 32'd12, 1'b1)};
    directed_q = {directed_q, mk(32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000,
                                 32'h0000_0003, 32'hFFFF_FFFD, 32'h0002_8000, 1'b0)};
    directed_q = {directed_q, mk(32'h0005_0000, 32'h0000_0001, 32'hFFFF_0001,
                                 32'h7FFF_0000, 32'h8001_0000, 32'h0000_0000, 1'b0)};
    directed_q = {directed_q, mk(32'hFFF0_0000, 32'h0010_0000, 32'h0000_0005,
                                 32'hFFFF_FFFB, 32'h0001_8000, 32'hFFFE_8000, 1'b0)};
    // Restart just after results resume, then refill to a full window.
    directed_q = {directed_q, mk(ALT_A, ALT_5, PMAX, PMIN, ONES, 32'd1, 1'b1)};
    directed_q = {directed_q, mk(PMIN, 32'd0, ALT_A, ALT_5, PMAX, ONES, 1'b0)};
    directed_q = {directed_q, mk(32'd1, PMAX, PMIN, ONES, ALT_A, ALT_5, 1'b0)};
    directed_q = {directed_q, mk(PMAX, ONES, 32'd0, 32'd1, PMIN, ALT_A, 1'b0)};
    foreach (directed_q[i]) put_sample(directed_q[i]);

    // Random: mostly long runs of valid samples with occasional restarts.
    prev = directed_q[directed_q.size() - 1];
    for (int n = 0; n < RAND_ITEMS; n++) begin
      s.restart = ($urandom_range(0, 99) < 4);
      style = pick_style();
      for (int j = 0; j < COORDS; j++)
        s.coord[j] = rand_coord(prev.coord[j],
                                ($urandom_range(0, 4) == 0) ? pick_style() : style);
      put_sample(s);
      prev = s;
    end
    @(negedge clk);
    samples.valid <= 1'b0;

    // Drain the outstanding pairs, then watch a little longer for strays.
    while (pending_pairs != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0 && pending_pairs == 0)
      $display("catmull_rom_ribbon_interpolator_unit test passed");
    else
      $display("catmull_rom_ribbon_interpolator_unit test failed");
    $finish;
  end

endmodule

[catmull_rom_ribbon_interpolator_unit.f]
sv/crr_pkg.sv
sv/crr_ifs.sv
sv/crr_front.sv
sv/crr_queue.sv
sv/crr_lane.sv
sv/crr_back.sv
sv/catmull_rom_ribbon_interpolator_unit.sv
sv/crr_checker.sv
dv/crr_curve_checker.sv
dv/tb.sv
